// ===== rtl/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

	localparam int ANGLE_W = 31;
	localparam int VALUE_W = 31;
	localparam int MAG_W   = 30;
	localparam int TERMS_W = 5;
	localparam int X2_W    = 32;
	localparam int LIMB_W  = 32;
	localparam int DIV_W   = 12;
	localparam int DIGIT_W = 4;

	localparam logic signed [ANGLE_W-1:0] PI_Q28     = 31'sd843314857;
	localparam logic signed [ANGLE_W-1:0] NEG_PI_Q28 = -31'sd843314857;
	localparam logic signed [VALUE_W-1:0] ONE_Q29    = 31'sd536870912;
	localparam logic signed [VALUE_W-1:0] NEG_ONE_Q29 = -31'sd536870912;
	localparam logic [TERMS_W-1:0]        MAX_TERMS_RST = 5'd13;

	// start request handed from the stream front end to the series engine
	typedef struct packed {
		logic             op;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sct_req_t;

	// finished result offered by the series engine
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
	} sct_res_t;

endpackage

// ===== rtl/sine_cosine_taylor_series_unit.sv =====
`timescale 1ns / 1ps

// Sine / cosine by Taylor partial sum.
//
// Input stream (s_*): one transaction per angle. s_tdata holds the angle in
// radians, signed Q3.28; s_tuser selects sine (0) or cosine (1). Angles past
// plus or minus pi are clamped and flagged.
// Output stream (m_*): one transaction per input. m_tdata holds the result,
// signed Q2.29 saturated to plus or minus one; m_tuser is the range flag.
// Configuration (cfg_*): a single register, max_terms, the most series terms
// summed after the first; write it only while the unit is idle.
//
// Each term runs on one shared 32x32 multiplier (two limb products) and a
// 4-bit-per-cycle restoring divider by the two factorial factors, which
// runs NSTEP = ceil((ACC_WIDTH + 3) / 4) steps per term. A zero quotient
// term ends the sum before max_terms is reached.
// One angle is in flight at a time; s_tready is low while it is worked on.
// A finished result sits in the output register; while the receiver stalls,
// the engine holds its next result and the input stays closed.
// Reset clears all handshake state and sets max_terms to 13.

module sine_cosine_taylor_series_unit #(
	parameter int ACC_WIDTH = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,    // [4:0] max_terms
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // [30:0] angle, [31] zero
	input  logic        s_tuser,     // [0] operation
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [30:0] value, [31] zero
	output logic        m_tuser      // [0] range_error
);
	import sct_pkg::*;

	logic [TERMS_W-1:0]        max_terms_q;
	logic                      err_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_err_q;

	logic signed [ANGLE_W-1:0] angle;
	logic signed [ANGLE_W-1:0] clamped;
	logic                      clamp_err;
	logic signed [ANGLE_W-1:0] abs_angle;
	sct_req_t                  req;
	sct_res_t                  res;
	logic                      core_idle;
	logic                      res_ready;
	logic                      in_fire;

	// Configuration register: always ready; user writes it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_terms_q <= MAX_TERMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_terms_q <= cfg_data;
		end
	end

	// Clamp the angle to [-pi, pi] and split into sign and magnitude.
	assign angle = $signed(s_tdata[ANGLE_W-1:0]);

	always_comb begin
		clamped   = angle;
		clamp_err = 1'b0;
		if (angle > PI_Q28) begin
			clamped   = PI_Q28;
			clamp_err = 1'b1;
		end else if (angle < NEG_PI_Q28) begin
			clamped   = NEG_PI_Q28;
			clamp_err = 1'b1;
		end
	end

	assign abs_angle = clamped[ANGLE_W-1] ? -clamped : clamped;
	assign req.op    = s_tuser;
	assign req.neg   = clamped[ANGLE_W-1];
	assign req.mag   = abs_angle[MAG_W-1:0];

	// Take a new angle only when the engine is idle.
	assign s_tready = core_idle;
	assign in_fire  = s_tvalid && s_tready;

	// Hold the range flag for the angle in flight.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q <= clamp_err;
		end
	end

	sct_core #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire),
		.req       (req),
		.max_terms (max_terms_q),
		.res_ready (res_ready),
		.idle      (core_idle),
		.res       (res)
	);

	// Output register: load when empty or being drained, drop once taken.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_value_q <= res.value;
			out_err_q   <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_value_q};
	assign m_tuser  = out_err_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !core_idle)
		else $error("engine stayed idle after an accepted angle");

endmodule

// ===== rtl/sct_divstep.sv =====
`timescale 1ns / 1ps

module sct_divstep (
	input  logic [sct_pkg::DIV_W-1:0]   rem,
	input  logic [sct_pkg::DIV_W-1:0]   divisor,
	input  logic [sct_pkg::DIGIT_W-1:0] bits,
	output logic [sct_pkg::DIV_W-1:0]   rem_nxt,
	output logic [sct_pkg::DIGIT_W-1:0] qdig
);
	import sct_pkg::*;

	// restoring division, one quotient bit per step, remainder stays below the divisor
	always_comb begin
		logic [DIV_W-1:0] r;
		logic [DIV_W:0]   cur;
		r    = rem;
		qdig = '0;
		for (int k = DIGIT_W - 1; k >= 0; k--) begin
			cur = {r, bits[k]};
			if (cur >= {1'b0, divisor}) begin
				r       = DIV_W'(cur - {1'b0, divisor});
				qdig[k] = 1'b1;
			end else begin
				r = cur[DIV_W-1:0];
			end
		end
		rem_nxt = r;
	end

endmodule

// ===== rtl/sct_core.sv =====
`timescale 1ns / 1ps

module sct_core #(
	parameter int ACC_WIDTH = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  sct_pkg::sct_req_t            req,
	input  logic [sct_pkg::TERMS_W-1:0]  max_terms,
	input  logic                         res_ready,
	output logic                         idle,
	output sct_pkg::sct_res_t            res
);
	import sct_pkg::*;

	localparam int F     = ACC_WIDTH - 4;
	localparam int TW    = ACC_WIDTH - 1;
	localparam int PW    = TW + LIMB_W;
	localparam int DW    = PW - 28;
	localparam int NSTEP = (DW + DIGIT_W - 1) / DIGIT_W;
	localparam int DVB   = NSTEP * DIGIT_W;
	localparam int CNT_W = $clog2(NSTEP);
	localparam int RW    = ACC_WIDTH + 1 - (F - 29);
	localparam int IDX_W = TERMS_W + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQR  = 4'd1;
	localparam logic [3:0] ST_XSQ  = 4'd2;
	localparam logic [3:0] ST_TERM = 4'd3;
	localparam logic [3:0] ST_MHI  = 4'd4;
	localparam logic [3:0] ST_MADD = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_ACC  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;
	localparam logic [3:0] ST_RND  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]                  state_q;
	logic                        op_q;
	logic [MAG_W-1:0]            mag_q;
	logic [X2_W-1:0]             x2_q;
	logic [TW-1:0]               term_q;
	logic                        tneg_q;
	logic signed [ACC_WIDTH-1:0] sum_q;
	logic [IDX_W-1:0]            i_q;
	logic [DIV_W-1:0]            d_q;
	logic [2*LIMB_W-1:0]         prod_q;
	logic [PW-1:0]               acc_q;
	logic [DVB-1:0]              dvd_q;
	logic [DIV_W-1:0]            rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        sneg_q;
	logic [ACC_WIDTH-1:0]        smag_q;
	logic signed [VALUE_W-1:0]   value_q;

	logic [TW-1:0]               term_init;
	logic                        neg_init;
	logic [2*LIMB_W-1:0]         term_ext;
	logic [LIMB_W-1:0]           mul_a;
	logic [LIMB_W-1:0]           mul_b;
	logic [2*LIMB_W-1:0]         mul_p;
	logic [5:0]                  fac_n;
	logic [6:0]                  fac_m;
	logic [12:0]                 fac_p;
	logic [PW-1:0]               prod_sum;
	logic [DIV_W-1:0]            rem_nxt;
	logic [DIGIT_W-1:0]          qdig;
	logic [TW-1:0]               q_term;
	logic [ACC_WIDTH-1:0]        q_ext;
	logic [ACC_WIDTH:0]          rnd_sum;
	logic [RW-1:0]               rnd_mag;
	logic [VALUE_W-1:0]          sat_mag;

	assign term_init = req.op ? (TW'(1) << F) : (TW'(req.mag) << (F - 28));
	assign neg_init  = !req.op && req.neg;
	assign term_ext  = (2*LIMB_W)'(term_q);

	// shared multiplier: squares the angle once, then takes the two term limbs by x^2
	always_comb begin
		case (state_q)
			ST_SQR: begin
				mul_a = LIMB_W'(mag_q);
				mul_b = LIMB_W'(mag_q);
			end
			ST_TERM: begin
				mul_a = term_ext[LIMB_W-1:0];
				mul_b = x2_q;
			end
			ST_MHI: begin
				mul_a = term_ext[2*LIMB_W-1:LIMB_W];
				mul_b = x2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// next two factorial factors: sine (2i+1)(2i), cosine (2i)(2i-1)
	assign fac_n = {i_q[TERMS_W-1:0], 1'b0};
	assign fac_m = op_q ? ({1'b0, fac_n} - 7'd1) : ({1'b0, fac_n} + 7'd1);
	assign fac_p = {7'b0, fac_n} * {6'b0, fac_m};

	assign prod_sum = acc_q + (PW'(prod_q) << LIMB_W);

	sct_divstep u_divstep (
		.rem     (rem_q),
		.divisor (d_q),
		.bits    (dvd_q[DVB-1 -: DIGIT_W]),
		.rem_nxt (rem_nxt),
		.qdig    (qdig)
	);

	assign q_term  = dvd_q[TW-1:0];
	assign q_ext   = {1'b0, q_term};
	assign rnd_sum = {1'b0, smag_q} + ((ACC_WIDTH + 1)'(1) << (F - 30));
	assign rnd_mag = rnd_sum[ACC_WIDTH -: RW];
	assign sat_mag = (rnd_mag > RW'(ONE_Q29)) ? ONE_Q29 : rnd_mag[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_XSQ;
				ST_XSQ:  state_q <= ST_TERM;
				ST_TERM: state_q <= (i_q > {1'b0, max_terms}) ? ST_FIN : ST_MHI;
				ST_MHI:  state_q <= ST_MADD;
				ST_MADD: state_q <= ST_DIV;
				ST_DIV:  if (cnt_q == CNT_W'(NSTEP - 1)) state_q <= ST_ACC;
				ST_ACC:  state_q <= (q_term == '0) ? ST_FIN : ST_TERM;
				ST_FIN:  state_q <= ST_RND;
				ST_RND:  state_q <= ST_DONE;
				ST_DONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q   <= req.op;
				mag_q  <= req.mag;
				term_q <= term_init;
				tneg_q <= neg_init;
				sum_q  <= neg_init ? -$signed({1'b0, term_init}) : $signed({1'b0, term_init});
				i_q    <= IDX_W'(1);
			end
			ST_SQR: prod_q <= mul_p;
			ST_XSQ: x2_q <= prod_q[28 +: X2_W];
			ST_TERM: begin
				d_q    <= fac_p[DIV_W-1:0];
				prod_q <= mul_p;
			end
			ST_MHI: begin
				acc_q  <= PW'(prod_q);
				prod_q <= mul_p;
			end
			ST_MADD: begin
				dvd_q <= DVB'(prod_sum[PW-1:28]);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[DVB-DIGIT_W-1:0], qdig};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_ACC: begin
				// alternate the sign, then fold the new term into the sum
				term_q <= q_term;
				tneg_q <= !tneg_q;
				sum_q  <= tneg_q ? (sum_q + $signed(q_ext)) : (sum_q - $signed(q_ext));
				i_q    <= i_q + IDX_W'(1);
			end
			ST_FIN: begin
				sneg_q <= sum_q[ACC_WIDTH-1];
				smag_q <= sum_q[ACC_WIDTH-1] ? ACC_WIDTH'(-sum_q) : ACC_WIDTH'(sum_q);
			end
			ST_RND: value_q <= sneg_q ? -$signed(sat_mag) : $signed(sat_mag);
			default: ;
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE);
	assign res.value = value_q;

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_SQR))
		else $error("start did not launch the series");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < d_q))
		else $error("division remainder reached the divisor");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> (i_q <= ({1'b0, max_terms} + IDX_W'(1))))
		else $error("term index ran past max_terms");

	a_value_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (value_q <= ONE_Q29 && value_q >= NEG_ONE_Q29))
		else $error("result outside plus or minus one");

endmodule

// ===== verif/sincos_tb_pkg.sv =====
`timescale 1ns / 1ps

package sincos_tb_pkg;

	import sct_pkg::*;

	typedef enum logic {
		OP_SIN = 1'b0,
		OP_COS = 1'b1
	} trig_op_e;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      range_error;
	} sincos_result_t;

endpackage

// ===== verif/sincos_checker.sv =====
`timescale 1ns / 1ps

module sincos_checker
	import sct_pkg::*;
	import sincos_tb_pkg::*;
#(
	parameter int ACC_W = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          mismatches,
	output int          outstanding
);

	localparam int FRAC = ACC_W - 4;

	logic [TERMS_W-1:0] term_limit;
	sincos_result_t     results_due[$];

	// Taylor partial sum at ACC_W - 4 fraction bits, rounded and clipped to Q2.29
	function automatic sincos_result_t taylor_sincos(trig_op_e op,
			logic signed [ANGLE_W-1:0] angle, logic [TERMS_W-1:0] limit);
		sincos_result_t r;
		longint         ang;
		longint         total;
		longint         res;
		logic [63:0]    mag;
		logic [63:0]    x2;
		logic [63:0]    term;
		logic [63:0]    divisor;
		logic [63:0]    smag;
		logic [127:0]   wide;
		logic           term_neg;
		logic           sum_neg;
		int             i;
		r.range_error = 1'b0;
		ang = angle;
		if (ang > longint'(PI_Q28)) begin
			ang = PI_Q28;
			r.range_error = 1'b1;
		end
		if (ang < longint'(NEG_PI_Q28)) begin
			ang = NEG_PI_Q28;
			r.range_error = 1'b1;
		end
		mag = (ang < 0) ? -ang : ang;
		x2 = (mag * mag) >> 28;
		if (op == OP_COS) begin
			term = 64'd1 << FRAC;
			term_neg = 1'b0;
		end else begin
			term = mag << (FRAC - 28);
			term_neg = ang < 0;
		end
		total = term_neg ? -longint'(term) : longint'(term);
		for (i = 1; i <= int'(limit); i++) begin
			divisor = (op == OP_COS) ? (2 * i) * (2 * i - 1) : (2 * i + 1) * (2 * i);
			wide = (128'(term) * 128'(x2)) / (128'(divisor) << 28);
			term = wide[63:0];
			if (term == 0)
				break;
			term_neg = !term_neg;
			total += term_neg ? -longint'(term) : longint'(term);
		end
		sum_neg = total < 0;
		smag = sum_neg ? -total : total;
		// round half away from zero, then clip to one
		smag = (smag + (64'd1 << (FRAC - 30))) >> (FRAC - 29);
		if (smag > 64'(ONE_Q29))
			smag = 64'(ONE_Q29);
		res = sum_neg ? -longint'(smag) : longint'(smag);
		r.value = res[VALUE_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sincos_result_t want;
		int             errs;
		if (!arst_n) begin
			term_limit <= MAX_TERMS_RST;
			mismatches <= 0;
			outstanding <= 0;
			results_due.delete();
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready)
				term_limit <= cfg_data;
			if (s_tvalid && s_tready)
				results_due.push_back(taylor_sincos(trig_op_e'(s_tuser),
					s_tdata[ANGLE_W-1:0], term_limit));
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result value %0d range_error %0b", $time,
						$signed(m_tdata[VALUE_W-1:0]), m_tuser);
					errs++;
				end else begin
					want = results_due.pop_front();
					if (m_tdata[VALUE_W-1:0] !== want.value) begin
						$display("%0t: value expected %0d actual %0d", $time,
							want.value, $signed(m_tdata[VALUE_W-1:0]));
						errs++;
					end
					if (m_tuser !== want.range_error) begin
						$display("%0t: range_error expected %0b actual %0b", $time,
							want.range_error, m_tuser);
						errs++;
					end
				end
			end
			mismatches <= mismatches + errs;
			outstanding <= results_due.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import sct_pkg::*;
	import sincos_tb_pkg::*;

	// generous ceiling: every item at its slowest series plus both sides' worst gaps
	localparam int CYCLE_LIMIT   = 1_200_000;
	localparam int PHASE_ITEMS   = 138;
	localparam int SQUEEZE_LEN   = 600;
	localparam int DRAIN_CYCLES  = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int          mismatches;
	int          outstanding;
	int          cycles;
	bit          calm;        // no idling on either side when set
	bit          squeeze_req; // receiver holds off for a long stretch

	sine_cosine_taylor_series_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	sincos_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sine_cosine_taylor_series_unit: mismatch");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none once calm.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				m_tready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
				squeeze_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one angle; an optional idle burst goes first. Return at the edge
	// where the transaction is taken, so a back-to-back item keeps tvalid high.
	task automatic send_angle(trig_op_e op, logic signed [ANGLE_W-1:0] ang);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ang};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold until every expected result has come back. The checker's count is
	// registered, so wait for the next edge before testing it.
	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_max_terms(logic [TERMS_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly angles inside [-pi, pi]; some near the clamp points, some tiny,
	// and some anywhere in the 31-bit field.
	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		longint a;
		case ($urandom_range(0, 9))
			0: a = $signed(31'($urandom()));
			1: a = longint'(PI_Q28) * ($urandom_range(0, 1) ? 1 : -1)
				+ longint'($urandom_range(0, 64)) - 32;
			2: a = longint'($urandom_range(0, 8192)) - 4096;
			default: a = longint'($urandom_range(0, 2 * 843314857)) - longint'(PI_Q28);
		endcase
		return a[ANGLE_W-1:0];
	endfunction

	initial begin
		logic signed [ANGLE_W-1:0] edge_angles[12];
		int                        phase_terms[8];
		int                        p;
		int                        k;
		logic [TERMS_W-1:0]        n;

		edge_angles = '{31'sd0, 31'sd1, -31'sd1, PI_Q28, NEG_PI_Q28,
			PI_Q28 + 31'sd1, NEG_PI_Q28 - 31'sd1, 31'h3FFF_FFFF, 31'h4000_0000,
			31'sd421657428, -31'sd421657428, 31'h1555_5555};
		// -1 picks a random limit in the middle, -2 anywhere in the field
		phase_terms = '{1, 16, 31, 0, -1, -2, 13, 7};

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_SIN;
		calm = 1'b0;
		squeeze_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, smallest steps, both clamp points and just past them, the
		// field's extremes, a quarter turn each way and one more angle, for sine and
		// cosine alike. These run at the reset limit.
		foreach (edge_angles[i]) begin
			send_angle(OP_SIN, edge_angles[i]);
			send_angle(OP_COS, edge_angles[i]);
		end
		s_tvalid <= 1'b0;

		for (p = 0; p < 8; p++) begin
			wait_drained();
			if (phase_terms[p] == -1)
				n = TERMS_W'($urandom_range(2, 15));
			else if (phase_terms[p] == -2)
				n = TERMS_W'($urandom_range(0, 31));
			else
				n = TERMS_W'(phase_terms[p]);
			set_max_terms(n);
			calm = (p == 7);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// stall the receiver long enough to back the unit up to its input
				if (p == 1 && k == 40)
					squeeze_req = 1'b1;
				send_angle($urandom_range(0, 1) ? OP_COS : OP_SIN, pick_angle());
			end
			s_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sine_cosine_taylor_series_unit: match");
		else
			$display("sine_cosine_taylor_series_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sct_pkg.sv
rtl/sct_divstep.sv
rtl/sct_core.sv
rtl/sine_cosine_taylor_series_unit.sv
verif/sincos_tb_pkg.sv
verif/sincos_checker.sv
verif/testbench.sv
